FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define VGMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define VGMA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/vgma_pkg.sv
package vgma_pkg;

  // Word field widths
  localparam int IDX_W       = 18;
  localparam int COMP_W      = 4;
  localparam int SAMPLE_W    = 64;
  localparam int ADDR_W      = 23;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 88;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 7;
  localparam int EXTENT_W    = 7;
  localparam int GHOST_W     = 4;
  localparam int AXIS_W      = 2;
  localparam int NCOMP_W     = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_EXTENT_FIRST    = 3'd0,
    CFG_EXTENT_SECOND   = 3'd1,
    CFG_EXTENT_THIRD    = 3'd2,
    CFG_GHOST_WIDTH     = 3'd3,
    CFG_EXTEND_AXIS     = 3'd4,
    CFG_LOWER_SIDE      = 3'd5,
    CFG_COMPONENT_COUNT = 3'd6
  } cfg_reg_t;

  localparam logic [EXTENT_W-1:0] EXTENT_RST = 7'd1;
  localparam logic [GHOST_W-1:0]  GHOST_RST  = 4'd1;
  localparam logic [AXIS_W-1:0]   AXIS_RST   = 2'd0;
  localparam logic [NCOMP_W-1:0]  NCOMP_RST  = 5'd1;

  // Parameter defaults
  localparam int MAX_EXTENT_DEF     = 64;
  localparam int MAX_GHOST_DEF      = 8;
  localparam int MAX_COMPONENTS_DEF = 16;
  localparam int DIMS_DEF           = 3;
  localparam int DATA_WIDTH_DEF     = 64;

  // Quotient bits resolved per divider stage; divides IDX_W
  localparam int DIV_STEP   = 3;
  localparam int DIV_STAGES = IDX_W / DIV_STEP;

endpackage

FILE: rtl/volume_ghost_merge_address.sv
// Channel  Dir  Ports                     Word layout
// in_      in   tvalid tready tdata tuser  tdata: component, point_index, sample; tuser: from_ghost
// out_     out  tvalid tready tdata tuser  tdata: dest_address, sample_out; tuser: bad_index
// cfg_     in   valid ready index data     one register per write, always ready
//
// One word per cycle while the output buffer has room. After acceptance a word passes the
// input register, two pipelined restoring dividers (DIV_STEP quotient bits per stage)
// that split the point index, then shift, two multiply-add stages and a two-entry
// output buffer. Reset (rst_n low, synchronous) empties the pipe and loads register
// defaults. The whole pipe holds only while both buffer entries are full.
`include "assert_macros.svh"

module volume_ghost_merge_address #(
  parameter int MAX_EXTENT     = vgma_pkg::MAX_EXTENT_DEF,
  parameter int MAX_GHOST      = vgma_pkg::MAX_GHOST_DEF,
  parameter int MAX_COMPONENTS = vgma_pkg::MAX_COMPONENTS_DEF,
  parameter int DIMS           = vgma_pkg::DIMS_DEF,
  parameter int DATA_WIDTH     = vgma_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [3:0] component, [21:4] point_index, [85:22] sample
  input  logic [vgma_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] from_ghost
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [22:0] dest_address, [86:23] sample_out
  output logic [vgma_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] bad_index
  output logic                                out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vgma_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [vgma_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SMAX   = (MAX_EXTENT > MAX_GHOST) ? MAX_EXTENT : MAX_GHOST;
  localparam int SW     = $clog2(SMAX + 1);
  localparam int XW     = $clog2(MAX_EXTENT + MAX_GHOST + 1);
  localparam int CW     = $clog2(MAX_COMPONENTS + 1);
  localparam int ND     = vgma_pkg::DIV_STAGES;
  localparam int IDX_W  = vgma_pkg::IDX_W;
  localparam int ADDR_W = vgma_pkg::ADDR_W;

  typedef struct packed {
    logic                          vld;
    logic                          ghost;
    logic [vgma_pkg::COMP_W-1:0]   comp;
    logic [DATA_WIDTH-1:0]         smp;
    logic [SW-1:0]                 c0;
    logic [SW-1:0]                 rem;
    logic [IDX_W-1:0]              dq;
  } div_t;

  typedef struct packed {
    logic                          vld;
    logic                          bad;
    logic [vgma_pkg::COMP_W-1:0]   comp;
    logic [DATA_WIDTH-1:0]         smp;
    logic [2:0][XW-1:0]            c;
  } sta_t;

  typedef struct packed {
    logic                          vld;
    logic                          bad;
    logic [vgma_pkg::COMP_W-1:0]   comp;
    logic [DATA_WIDTH-1:0]         smp;
    logic [XW-1:0]                 c0;
    logic [ADDR_W-1:0]             p;
  } stb_t;

  typedef struct packed {
    logic                          vld;
    logic                          bad;
    logic [DATA_WIDTH-1:0]         smp;
    logic [ADDR_W-1:0]             q;
    logic [ADDR_W-1:0]             cofs;
  } stc_t;

  typedef struct packed {
    logic [ADDR_W-1:0]             addr;
    logic [DATA_WIDTH-1:0]         smp;
    logic                          bad;
  } res_t;

  function automatic logic [SW-1:0] clamp_ext(logic [vgma_pkg::EXTENT_W-1:0] v, int hi);
    logic [SW-1:0] r;
    if (v == '0) begin
      r = SW'(1);
    end else if (int'(v) > hi) begin
      r = SW'(hi);
    end else begin
      r = SW'(v);
    end
    return r;
  endfunction

  // Configuration registers
  logic [2:0][vgma_pkg::EXTENT_W-1:0] cfg_ext_r;
  logic [vgma_pkg::GHOST_W-1:0]       cfg_gw_r;
  logic [vgma_pkg::AXIS_W-1:0]        cfg_axis_r;
  logic                               cfg_lower_r;
  logic [vgma_pkg::NCOMP_W-1:0]       cfg_ncomp_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ext_r   <= {3{vgma_pkg::EXTENT_RST}};
      cfg_gw_r    <= vgma_pkg::GHOST_RST;
      cfg_axis_r  <= vgma_pkg::AXIS_RST;
      cfg_lower_r <= 1'b0;
      cfg_ncomp_r <= vgma_pkg::NCOMP_RST;
    end else if (cfg_valid) begin
      unique case (vgma_pkg::cfg_reg_t'(cfg_index))
        vgma_pkg::CFG_EXTENT_FIRST:    cfg_ext_r[0] <= cfg_data[vgma_pkg::EXTENT_W-1:0];
        vgma_pkg::CFG_EXTENT_SECOND:   cfg_ext_r[1] <= cfg_data[vgma_pkg::EXTENT_W-1:0];
        vgma_pkg::CFG_EXTENT_THIRD:    cfg_ext_r[2] <= cfg_data[vgma_pkg::EXTENT_W-1:0];
        vgma_pkg::CFG_GHOST_WIDTH:     cfg_gw_r     <= cfg_data[vgma_pkg::GHOST_W-1:0];
        vgma_pkg::CFG_EXTEND_AXIS:     cfg_axis_r   <= cfg_data[vgma_pkg::AXIS_W-1:0];
        vgma_pkg::CFG_LOWER_SIDE:      cfg_lower_r  <= cfg_data[0];
        vgma_pkg::CFG_COMPONENT_COUNT: cfg_ncomp_r  <= cfg_data[vgma_pkg::NCOMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived geometry, registered
  logic [2:0][SW-1:0]  volc;
  logic [SW-1:0]       gwc;
  logic [1:0]          axisc;
  logic [CW-1:0]       ncompc;

  logic [2:0][SW-1:0]  vol_r;
  logic [2:0][SW-1:0]  srcg_r;
  logic [2:0][XW-1:0]  ext_r;
  logic [1:0]          axis_r;
  logic [XW-1:0]       offv_r;
  logic [XW-1:0]       offg_r;
  logic [CW-1:0]       ncomp_r;
  logic [ADDR_W-1:0]   ext01_r;
  logic [ADDR_W-1:0]   extpts_r;

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      volc[d] = (d >= DIMS) ? SW'(1) : clamp_ext(cfg_ext_r[d], MAX_EXTENT);
    end
    gwc   = clamp_ext(vgma_pkg::EXTENT_W'(cfg_gw_r), MAX_GHOST);
    axisc = (int'(cfg_axis_r) >= DIMS || cfg_axis_r == 2'd3) ? 2'd0 : cfg_axis_r;
    if (cfg_ncomp_r == '0) begin
      ncompc = CW'(1);
    end else if (int'(cfg_ncomp_r) > MAX_COMPONENTS) begin
      ncompc = CW'(MAX_COMPONENTS);
    end else begin
      ncompc = CW'(cfg_ncomp_r);
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < 3; d++) begin
      vol_r[d]  <= volc[d];
      srcg_r[d] <= (axisc == 2'(d)) ? gwc : volc[d];
      ext_r[d]  <= XW'(volc[d]) + ((axisc == 2'(d)) ? XW'(gwc) : XW'(0));
    end
    axis_r   <= axisc;
    offv_r   <= cfg_lower_r ? XW'(gwc) : XW'(0);
    offg_r   <= cfg_lower_r ? XW'(0) : XW'(volc[axisc]);
    ncomp_r  <= ncompc;
    ext01_r  <= ADDR_W'(ext_r[0]) * ADDR_W'(ext_r[1]);
    extpts_r <= ext01_r * ADDR_W'(ext_r[2]);
  end

  // Pipeline control
  logic       en;
  logic       push;
  logic       pop;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;

  // Input register and dividers: index / src0, then quotient / src1
  div_t div_r [0:2*ND];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r[0].vld <= 1'b0;
    end else if (en) begin
      div_r[0].vld   <= in_tvalid;
      div_r[0].ghost <= in_tuser;
      div_r[0].comp  <= in_tdata[3:0];
      div_r[0].smp   <= in_tdata[22 +: DATA_WIDTH];
      div_r[0].c0    <= '0;
      div_r[0].rem   <= '0;
      div_r[0].dq    <= in_tdata[21:4];
    end
  end

  for (genvar k = 1; k <= 2 * ND; k++) begin : g_div
    div_t          nxt;
    logic [SW-1:0] dvs;
    logic [SW:0]   trial;

    always_comb begin
      nxt = div_r[k-1];
      if (k == ND + 1) begin
        nxt.c0  = div_r[k-1].rem;
        nxt.rem = '0;
      end
      if (k <= ND) begin
        dvs = div_r[k-1].ghost ? srcg_r[0] : vol_r[0];
      end else begin
        dvs = div_r[k-1].ghost ? srcg_r[1] : vol_r[1];
      end
      trial = '0;
      for (int j = 0; j < vgma_pkg::DIV_STEP; j++) begin
        trial  = {nxt.rem, nxt.dq[IDX_W-1]};
        nxt.dq = {nxt.dq[IDX_W-2:0], 1'b0};
        if (trial >= {1'b0, dvs}) begin
          trial     = trial - {1'b0, dvs};
          nxt.dq[0] = 1'b1;
        end
        nxt.rem = trial[SW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_r[k].vld <= 1'b0;
      end else if (en) begin
        div_r[k] <= nxt;
      end
    end
  end

  // Stage A: range check and shift on the extended axis
  sta_t          sta_r;
  sta_t          sta_nxt;
  div_t          dl;
  logic [SW-1:0] src2;
  logic [XW-1:0] off;

  always_comb begin
    dl   = div_r[2*ND];
    src2 = dl.ghost ? srcg_r[2] : vol_r[2];
    off  = dl.ghost ? offg_r : offv_r;
    sta_nxt.vld  = dl.vld;
    sta_nxt.bad  = (32'(dl.dq) >= 32'(src2)) || (32'(dl.comp) >= 32'(ncomp_r));
    sta_nxt.comp = dl.comp;
    sta_nxt.smp  = dl.smp;
    sta_nxt.c[0] = XW'(dl.c0);
    sta_nxt.c[1] = XW'(dl.rem);
    sta_nxt.c[2] = XW'(dl.dq[SW-1:0]);
    sta_nxt.c[axis_r] = sta_nxt.c[axis_r] + off;
  end

  // Stage B: c1 + e1 * c2
  stb_t stb_r;
  stb_t stb_nxt;

  always_comb begin
    stb_nxt.vld  = sta_r.vld;
    stb_nxt.bad  = sta_r.bad;
    stb_nxt.comp = sta_r.comp;
    stb_nxt.smp  = sta_r.smp;
    stb_nxt.c0   = sta_r.c[0];
    stb_nxt.p    = ADDR_W'(sta_r.c[1]) + ADDR_W'(ext_r[1]) * ADDR_W'(sta_r.c[2]);
  end

  // Stage C: c0 + e0 * p, component offset
  stc_t stc_r;
  stc_t stc_nxt;

  always_comb begin
    stc_nxt.vld  = stb_r.vld;
    stc_nxt.bad  = stb_r.bad;
    stc_nxt.smp  = stb_r.smp;
    stc_nxt.q    = ADDR_W'(stb_r.c0) + ADDR_W'(ext_r[0]) * stb_r.p;
    stc_nxt.cofs = ADDR_W'(stb_r.comp) * extpts_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sta_r.vld <= 1'b0;
      stb_r.vld <= 1'b0;
      stc_r.vld <= 1'b0;
    end else if (en) begin
      sta_r <= sta_nxt;
      stb_r <= stb_nxt;
      stc_r <= stc_nxt;
    end
  end

  // Two-entry output buffer
  res_t res_new;
  res_t head_r;
  res_t spare_r;

  always_comb begin
    res_new.addr = stc_r.bad ? '0 : (stc_r.q + stc_r.cofs);
    res_new.smp  = stc_r.smp;
    res_new.bad  = stc_r.bad;
  end

  assign push    = en && stc_r.vld;
  assign pop     = out_tvalid && out_tready;
  assign cnt_nxt = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cnt_r == 2'd2) begin
      head_r <= spare_r;
    end else if (push && (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop))) begin
      head_r <= res_new;
    end else if (push && cnt_r == 2'd1) begin
      spare_r <= res_new;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = vgma_pkg::OUT_TDATA_W'({vgma_pkg::SAMPLE_W'(head_r.smp), head_r.addr});
  assign out_tuser  = head_r.bad;

  `VGMA_ASSERT(a_bad_addr_zero, (out_tvalid && out_tuser) |-> (out_tdata[ADDR_W-1:0] == '0), "bad word carries nonzero address")
  `VGMA_ASSERT(a_stall_only_full, !in_tready |-> (out_tvalid && cnt_r == 2'd2), "input held off with buffer space free")
  `VGMA_ASSERT(a_full_drain, (cnt_r == 2'd2 && out_tready) |=> (cnt_r == 2'd1), "full buffer did not drain by one")
  `VGMA_ASSERT_ALWAYS(a_cnt_range, (!rst_n || cnt_r != 2'd3), "output buffer count out of range")

endmodule

FILE: tb/tb_top.sv
module tb_top;
  import vgma_pkg::*;

  localparam int DIMS           = DIMS_DEF;
  localparam int MAX_EXTENT     = MAX_EXTENT_DEF;
  localparam int MAX_GHOST      = MAX_GHOST_DEF;
  localparam int MAX_COMPONENTS = MAX_COMPONENTS_DEF;
  localparam int RAND_PHASES    = 14;
  localparam int PHASE_WORDS    = 78;

  typedef struct {
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] sample;
    logic                bad;
  } merge_result_t;

  typedef struct {
    bit                  is_cfg;
    cfg_reg_t            which;
    logic [6:0]          value;
    logic                ghost;
    logic [COMP_W-1:0]   comp;
    logic [IDX_W-1:0]    idx;
    logic [SAMPLE_W-1:0] sample;
    bit                  typed;
    logic [ADDR_W-1:0]   exp_addr;
    logic                exp_bad;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  logic [EXTENT_W-1:0] extent_q [3];
  logic [GHOST_W-1:0]  ghost_width_q;
  logic [AXIS_W-1:0]   axis_q;
  logic                lower_q;
  logic [NCOMP_W-1:0]  ncomp_q;

  merge_result_t pending_results [$];
  stim_row_t     stim_rows [$];
  int            idle_mode = 0;
  int            errors = 0;
  int            words_sent = 0;
  int            settings_used = 1;
  int            flagged_seen = 0;

  volume_ghost_merge_address DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned active_axis();
    if (axis_q >= DIMS || axis_q > 2) return 0;
    return axis_q;
  endfunction

  function automatic int unsigned source_points(input logic ghost);
    int unsigned pts;
    int unsigned axis;
    axis = active_axis();
    pts = 1;
    for (int d = 0; d < 3; d++) begin
      if (d == axis && ghost) pts *= clamp_to(ghost_width_q, MAX_GHOST);
      else if (d < DIMS) pts *= clamp_to(extent_q[d], MAX_EXTENT);
    end
    return pts;
  endfunction

  function automatic merge_result_t merge_address(input logic ghost,
                                                  input logic [COMP_W-1:0] comp,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic [SAMPLE_W-1:0] sample);
    int unsigned vol [3];
    int unsigned src [3];
    int unsigned ext [3];
    int unsigned coord [3];
    int unsigned gw, ncomp, axis, src_pts, ext_pts, rest, addr;
    merge_result_t r;
    gw = clamp_to(ghost_width_q, MAX_GHOST);
    ncomp = clamp_to(ncomp_q, MAX_COMPONENTS);
    axis = active_axis();
    src_pts = 1;
    ext_pts = 1;
    for (int d = 0; d < 3; d++) begin
      vol[d] = (d < DIMS) ? clamp_to(extent_q[d], MAX_EXTENT) : 1;
      src[d] = vol[d];
      ext[d] = vol[d];
      if (d == axis) begin
        if (ghost) src[d] = gw;
        ext[d] = vol[d] + gw;
      end
      src_pts *= src[d];
      ext_pts *= ext[d];
    end
    r.sample = sample;
    r.bad = (idx >= src_pts) || (comp >= ncomp);
    r.addr = '0;
    if (!r.bad) begin
      rest = idx;
      for (int d = 0; d < 3; d++) begin
        coord[d] = rest % src[d];
        rest = rest / src[d];
      end
      if (!ghost && lower_q) coord[axis] += gw;
      if (ghost && !lower_q) coord[axis] += vol[axis];
      addr = coord[0] + ext[0] * (coord[1] + ext[1] * coord[2]) + comp * ext_pts;
      r.addr = addr[ADDR_W-1:0];
    end
    return r;
  endfunction

  function automatic void cfg_row(input cfg_reg_t which, input logic [6:0] value);
    stim_row_t r;
    r = '{which: CFG_EXTENT_FIRST, default: '0};
    r.is_cfg = 1'b1;
    r.which = which;
    r.value = value;
    stim_rows.push_back(r);
  endfunction

  function automatic void item_row(input logic ghost, input logic [COMP_W-1:0] comp,
                                   input logic [IDX_W-1:0] idx,
                                   input logic [SAMPLE_W-1:0] sample, input bit typed,
                                   input logic [ADDR_W-1:0] exp_addr, input logic exp_bad);
    stim_row_t r;
    r = '{which: CFG_EXTENT_FIRST, default: '0};
    r.ghost = ghost;
    r.comp = comp;
    r.idx = idx;
    r.sample = sample;
    r.typed = typed;
    r.exp_addr = exp_addr;
    r.exp_bad = exp_bad;
    stim_rows.push_back(r);
  endfunction

  function automatic logic [6:0] pick_reg(input int unsigned lo, input int unsigned hi);
    if ($urandom_range(0, 99) < 80) return 7'($urandom_range(lo, hi));
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic int sender_idle_pct();
    return (idle_mode == 1) ? 70 : (idle_mode == 3) ? 14 : 0;
  endfunction

  function automatic int receiver_stall_pct();
    return (idle_mode == 2) ? 70 : (idle_mode == 3) ? 14 : 0;
  endfunction

  always @(negedge clk) begin
    out_tready = ($urandom_range(0, 99) >= receiver_stall_pct());
  end

  always @(posedge clk) begin : check_results
    merge_result_t want;
    logic [ADDR_W-1:0]   got_addr;
    logic [SAMPLE_W-1:0] got_sample;
    if (rst_n && out_tvalid && out_tready) begin
      got_addr = out_tdata[ADDR_W-1:0];
      got_sample = out_tdata[ADDR_W+SAMPLE_W-1:ADDR_W];
      if (out_tuser) flagged_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word addr %0d sample %h bad %0b",
                 $time, got_addr, got_sample, out_tuser);
      end else begin
        want = pending_results.pop_front();
        if (got_addr !== want.addr) begin
          errors++;
          $display("%0t: dest_address expected %0d actual %0d", $time, want.addr, got_addr);
        end
        if (got_sample !== want.sample) begin
          errors++;
          $display("%0t: sample_out expected %h actual %h", $time, want.sample, got_sample);
        end
        if (out_tuser !== want.bad) begin
          errors++;
          $display("%0t: bad_index expected %0b actual %0b", $time, want.bad, out_tuser);
        end
      end
    end
  end

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [6:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = which;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (which)
      CFG_EXTENT_FIRST:    extent_q[0] = value[EXTENT_W-1:0];
      CFG_EXTENT_SECOND:   extent_q[1] = value[EXTENT_W-1:0];
      CFG_EXTENT_THIRD:    extent_q[2] = value[EXTENT_W-1:0];
      CFG_GHOST_WIDTH:     ghost_width_q = value[GHOST_W-1:0];
      CFG_EXTEND_AXIS:     axis_q = value[AXIS_W-1:0];
      CFG_LOWER_SIDE:      lower_q = value[0];
      CFG_COMPONENT_COUNT: ncomp_q = value[NCOMP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_word(input logic ghost, input logic [COMP_W-1:0] comp,
                           input logic [IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] sample,
                           input bit typed, input merge_result_t typed_res);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {2'b00, sample, idx, comp};
    in_tuser = ghost;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(typed ? typed_res : merge_address(ghost, comp, idx, sample));
    words_sent++;
  endtask

  initial begin : stimulus
    merge_result_t typed_res;
    merge_result_t none;
    logic                ghost;
    logic [COMP_W-1:0]   comp;
    logic [IDX_W-1:0]    idx;
    int unsigned         pts, ncomp;

    none = '{default: '0};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_EXTENT_FIRST;
    cfg_data = '0;
    extent_q[0] = EXTENT_RST;
    extent_q[1] = EXTENT_RST;
    extent_q[2] = EXTENT_RST;
    ghost_width_q = GHOST_RST;
    axis_q = AXIS_RST;
    lower_q = 1'b0;
    ncomp_q = NCOMP_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // defaults: one volume point, one ghost point appended on axis 0
    item_row(1'b0, 4'd0, 18'd0, 64'd0, 1, 23'd0, 1'b0);
    item_row(1'b1, 4'd0, 18'd0, '1, 1, 23'd1, 1'b0);
    item_row(1'b0, 4'd0, 18'd1, 64'h0123_4567_89ab_cdef, 1, 23'd0, 1'b1);
    item_row(1'b1, 4'd1, 18'd0, 64'hfedc_ba98_7654_3210, 1, 23'd0, 1'b1);
    item_row(1'b0, 4'd15, 18'h3ffff, 64'ha5a5_a5a5_5a5a_5a5a, 1, 23'd0, 1'b1);
    // largest shape, ghost below on the third axis
    cfg_row(CFG_EXTENT_FIRST, 7'd64);
    cfg_row(CFG_EXTENT_SECOND, 7'd64);
    cfg_row(CFG_EXTENT_THIRD, 7'd64);
    cfg_row(CFG_GHOST_WIDTH, 7'd8);
    cfg_row(CFG_EXTEND_AXIS, 7'd2);
    cfg_row(CFG_LOWER_SIDE, 7'd1);
    cfg_row(CFG_COMPONENT_COUNT, 7'd16);
    item_row(1'b0, 4'd15, 18'h3ffff, '1, 0, 23'd0, 1'b0);
    item_row(1'b1, 4'd15, 18'd32767, 64'h8000_0000_0000_0001, 0, 23'd0, 1'b0);
    item_row(1'b1, 4'd0, 18'd32768, 64'h1, 1, 23'd0, 1'b1);
    item_row(1'b0, 4'd0, 18'd0, 64'h2, 0, 23'd0, 1'b0);
    // out-of-range register values, bad axis selector
    cfg_row(CFG_EXTENT_FIRST, 7'd0);
    cfg_row(CFG_EXTENT_SECOND, 7'd127);
    cfg_row(CFG_EXTENT_THIRD, 7'd65);
    cfg_row(CFG_GHOST_WIDTH, 7'd0);
    cfg_row(CFG_EXTEND_AXIS, 7'd3);
    cfg_row(CFG_LOWER_SIDE, 7'd0);
    cfg_row(CFG_COMPONENT_COUNT, 7'd0);
    item_row(1'b0, 4'd0, 18'd4095, 64'h3, 0, 23'd0, 1'b0);
    item_row(1'b1, 4'd0, 18'd4095, 64'h4, 0, 23'd0, 1'b0);
    item_row(1'b1, 4'd0, 18'd4096, 64'h5, 1, 23'd0, 1'b1);
    item_row(1'b0, 4'd1, 18'd0, 64'h6, 1, 23'd0, 1'b1);
    // ghost width and component count above their maxima, middle axis
    cfg_row(CFG_EXTENT_FIRST, 7'd5);
    cfg_row(CFG_EXTENT_SECOND, 7'd3);
    cfg_row(CFG_EXTENT_THIRD, 7'd2);
    cfg_row(CFG_GHOST_WIDTH, 7'd15);
    cfg_row(CFG_EXTEND_AXIS, 7'd1);
    cfg_row(CFG_LOWER_SIDE, 7'd1);
    cfg_row(CFG_COMPONENT_COUNT, 7'd31);
    item_row(1'b0, 4'd15, 18'd29, 64'h7, 0, 23'd0, 1'b0);
    item_row(1'b1, 4'd7, 18'd79, 64'h8, 0, 23'd0, 1'b0);
    item_row(1'b1, 4'd3, 18'd80, 64'h9, 1, 23'd0, 1'b1);
    item_row(1'b0, 4'd2, 18'd13, 64'ha, 0, 23'd0, 1'b0);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        if (i == 0 || !stim_rows[i-1].is_cfg) begin
          drain();
          settings_used++;
        end
        write_reg(stim_rows[i].which, stim_rows[i].value);
      end else begin
        typed_res.addr = stim_rows[i].exp_addr;
        typed_res.sample = stim_rows[i].sample;
        typed_res.bad = stim_rows[i].exp_bad;
        send_word(stim_rows[i].ghost, stim_rows[i].comp, stim_rows[i].idx,
                  stim_rows[i].sample, stim_rows[i].typed, typed_res);
      end
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      idle_mode = 0;
      if (phase == 0) begin
        write_reg(CFG_EXTENT_FIRST, 7'd64);
        write_reg(CFG_EXTENT_SECOND, 7'd64);
        write_reg(CFG_EXTENT_THIRD, 7'd64);
        write_reg(CFG_GHOST_WIDTH, 7'd8);
        write_reg(CFG_COMPONENT_COUNT, 7'd16);
      end else if (phase == 1) begin
        write_reg(CFG_EXTENT_FIRST, 7'd1);
        write_reg(CFG_EXTENT_SECOND, 7'd1);
        write_reg(CFG_EXTENT_THIRD, 7'd1);
        write_reg(CFG_GHOST_WIDTH, 7'd1);
        write_reg(CFG_COMPONENT_COUNT, 7'd1);
      end else begin
        write_reg(CFG_EXTENT_FIRST, pick_reg(1, MAX_EXTENT));
        write_reg(CFG_EXTENT_SECOND, pick_reg(1, MAX_EXTENT));
        write_reg(CFG_EXTENT_THIRD, pick_reg(1, MAX_EXTENT));
        write_reg(CFG_GHOST_WIDTH, pick_reg(1, MAX_GHOST));
        write_reg(CFG_COMPONENT_COUNT, pick_reg(1, MAX_COMPONENTS));
      end
      write_reg(CFG_EXTEND_AXIS, pick_reg(0, 2));
      write_reg(CFG_LOWER_SIDE, pick_reg(0, 1));
      settings_used++;
      idle_mode = phase % 4;
      ncomp = clamp_to(ncomp_q, MAX_COMPONENTS);
      repeat (PHASE_WORDS) begin
        ghost = 1'($urandom_range(0, 1));
        pts = source_points(ghost);
        if ($urandom_range(0, 99) < 80) begin
          idx = IDX_W'($urandom_range(0, pts - 1));
          comp = COMP_W'($urandom_range(0, ncomp - 1));
        end else if ($urandom_range(0, 1) == 0) begin
          idx = IDX_W'($urandom);
          comp = COMP_W'($urandom_range(0, 15));
        end else begin
          // at or just past the last point, and at or just past the last component
          idx = IDX_W'($urandom_range(0, 1) ? pts : pts - 1);
          comp = COMP_W'($urandom_range(0, 1) ? ncomp : ncomp - 1);
        end
        send_word(ghost, comp, idx, {$urandom, $urandom}, 0, none);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words never arrived", $time, pending_results.size());
    end

    $display("Sent %0d words under %0d register settings, %0d flagged out of range,",
             words_sent, settings_used, flagged_seen);
    $display("with sender gaps and receiver back-pressure mixed in across the phases");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/vgma_pkg.sv
rtl/volume_ghost_merge_address.sv
tb/tb_top.sv
